/* hdl/sbox_xor_ladder_network_assert.svh */
// Assertion macros for the substitution ladder network.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SBOX_XOR_LADDER_NETWORK_ASSERT_SVH
`define SBOX_XOR_LADDER_NETWORK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SXL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SXL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sxl_pkg.sv */
// Shared constants and types for the substitution ladder network.
// No dependencies; used by every module of the block except sxl_ram.
`default_nettype none

package sxl_pkg;

    localparam int WORD_BITS        = 5;
    localparam int WORDS_PER_VECTOR = 4;
    localparam int TABLE_COUNT      = 2 * WORDS_PER_VECTOR - 1;
    localparam int ROUNDS           = WORDS_PER_VECTOR - 1;
    localparam int TABLE_ENTRIES    = 1 << WORD_BITS;
    localparam int SEL_BITS         = 3;

    // Command codes carried on the command field.
    localparam logic CMD_EVALUATE = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [SEL_BITS-1:0]  sel_t;

    // Write request into one table copy.
    typedef struct packed {
        logic  en;
        word_t addr;
        word_t data;
    } wr_t;

    // Registered lookup result of one table copy.
    typedef struct packed {
        word_t data;
        logic  unset;
    } rd_t;

endpackage

`default_nettype wire

/* hdl/sxl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sxl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/sxl_lane.sv */
// One copy of one substitution table with its written marks.
// Depends on sxl_pkg and sxl_ram.
`default_nettype none

module sxl_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  sxl_pkg::wr_t    wr,
    input  logic            rd_en,
    input  sxl_pkg::word_t  rd_addr,
    output sxl_pkg::rd_t    rd
);

    logic [sxl_pkg::TABLE_ENTRIES-1:0] mark_reg;
    logic                              unset_reg;
    sxl_pkg::word_t                    ram_rdata;

    sxl_ram #(
        .WIDTH (sxl_pkg::WORD_BITS),
        .DEPTH (sxl_pkg::TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Marks live in flops so that reset clears them all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else if (wr.en)
        begin
            mark_reg[wr.addr] <= 1'b1;
        end
    end

    // The mark is sampled on the same edge as the RAM read so both line up.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            unset_reg <= ~mark_reg[rd_addr];
        end
    end

    assign rd.data  = ram_rdata;
    assign rd.unset = unset_reg;

endmodule

`default_nettype wire

/* hdl/sbox_xor_ladder_network.sv */
// Throughput: one beat per cycle, evaluate or table write, with no gaps while out_stall is low.
// The three table-read stages and the output register set the depth; the first round reads
// at the input words, each later round at the XOR of the previous round's lookups.
// Reset clears pipeline valids and written marks at once; table RAMs are not
// cleared, and the block accepts beats in the first cycle after reset.
// Top level of the substitution ladder network: input stage, round stages and
// output register. Depends on sxl_pkg, sxl_lane and the assertion header.
`default_nettype none

`include "sbox_xor_ladder_network_assert.svh"

module sbox_xor_ladder_network (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [2:0]             table_select,
    input  sxl_pkg::word_t         table_address,
    input  sxl_pkg::word_t         table_data,
    input  sxl_pkg::word_t         word_in_0,
    input  sxl_pkg::word_t         word_in_1,
    input  sxl_pkg::word_t         word_in_2,
    input  sxl_pkg::word_t         word_in_3,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sxl_pkg::word_t         word_out_0,
    output sxl_pkg::word_t         word_out_1,
    output sxl_pkg::word_t         word_out_2,
    output sxl_pkg::word_t         word_out_3,
    output logic                   unset_entry_used
);

    // Stage 0 holds the accepted beat. Stage k (1..ROUNDS) holds the beat
    // after round k's table reads; the lookups themselves sit in the RAM
    // read registers inside the lanes of round k. Write beats travel down
    // the same pipe and update each round's table copies as they pass, so
    // every evaluate beat sees exactly the writes accepted before it.
    logic [sxl_pkg::ROUNDS:0] valid_reg;
    logic [sxl_pkg::ROUNDS:0] cmd_reg;
    sxl_pkg::sel_t            sel_reg   [0:sxl_pkg::ROUNDS-1];
    sxl_pkg::word_t           addr_reg  [0:sxl_pkg::ROUNDS-1];
    sxl_pkg::word_t           data_reg  [0:sxl_pkg::ROUNDS-1];
    sxl_pkg::word_t           words_reg [0:sxl_pkg::ROUNDS][0:sxl_pkg::WORDS_PER_VECTOR-1];
    logic [sxl_pkg::ROUNDS:1] flag_reg;

    // Per-stage advance: a stage takes a new beat when it is empty or when
    // the stage after it advances too, so bubbles collapse.
    logic [sxl_pkg::ROUNDS:0] ready;
    logic                     out_ready;

    // Lookup results and unset marks of every round; lanes that a round does
    // not use read as zero.
    sxl_pkg::rd_t                   rd_q    [1:sxl_pkg::ROUNDS][0:sxl_pkg::TABLE_COUNT-1];
    logic [sxl_pkg::TABLE_COUNT-1:0] unset_q [1:sxl_pkg::ROUNDS];
    logic [sxl_pkg::ROUNDS:0]        flag_any;

    // Output register, the skid between the pipe and the result side.
    logic                  out_valid_reg;
    sxl_pkg::word_t        word_out_reg [0:sxl_pkg::WORDS_PER_VECTOR-1];
    logic                  flag_out_reg;

    always_comb
    begin
        out_ready = !out_valid_reg || !out_stall;
        ready[sxl_pkg::ROUNDS] = !valid_reg[sxl_pkg::ROUNDS] || out_ready;
        for (int k = sxl_pkg::ROUNDS - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_stall = !ready[0];

    // Round r uses tables 0 .. TABLE_COUNT-r; each round has its own copy of
    // those tables so that all rounds can read in the same cycle.
    for (genvar r = 1; r <= sxl_pkg::ROUNDS; r++)
    begin : g_round
        logic rd_en;
        logic wr_go;

        assign rd_en = ready[r] && valid_reg[r-1] && (cmd_reg[r-1] == sxl_pkg::CMD_EVALUATE);
        assign wr_go = ready[r] && valid_reg[r-1] && (cmd_reg[r-1] == sxl_pkg::CMD_WRITE);

        for (genvar t = 0; t < sxl_pkg::TABLE_COUNT; t++)
        begin : g_lane
            if (t < sxl_pkg::TABLE_COUNT + 1 - r)
            begin : g_used
                sxl_pkg::wr_t   wr;
                sxl_pkg::word_t rd_addr;

                assign wr.en   = wr_go && (sel_reg[r-1] == sxl_pkg::sel_t'(t));
                assign wr.addr = addr_reg[r-1];
                assign wr.data = data_reg[r-1];

                // The first round reads the input words, the tail of the
                // layer repeating the leading words. Later rounds read the
                // XOR of neighboring lookups from the round before.
                if (r == 1)
                begin : g_first
                    if (t < sxl_pkg::WORDS_PER_VECTOR)
                    begin : g_head
                        assign rd_addr = words_reg[0][t];
                    end
                    else
                    begin : g_tail
                        assign rd_addr = words_reg[0][t - sxl_pkg::WORDS_PER_VECTOR];
                    end
                end
                else
                begin : g_later
                    assign rd_addr = rd_q[r-1][t].data ^ rd_q[r-1][t+1].data;
                end

                sxl_lane u_lane (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .wr      (wr),
                    .rd_en   (rd_en),
                    .rd_addr (rd_addr),
                    .rd      (rd_q[r][t])
                );

                assign unset_q[r][t] = rd_q[r][t].unset;
            end
            else
            begin : g_unused
                assign rd_q[r][t]    = '0;
                assign unset_q[r][t] = 1'b0;
            end
        end

        assign flag_any[r] = flag_reg[r] | (|unset_q[r]);
    end

    assign flag_any[0] = 1'b0;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= sxl_pkg::ROUNDS; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            // Write beats end at the last stage and never reach the output.
            if (out_ready)
            begin
                out_valid_reg <= valid_reg[sxl_pkg::ROUNDS]
                    && (cmd_reg[sxl_pkg::ROUNDS] == sxl_pkg::CMD_EVALUATE);
            end
        end
    end

    // Payload registers; they follow their stage's advance.
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            cmd_reg[0]      <= command;
            sel_reg[0]      <= table_select;
            addr_reg[0]     <= table_address;
            data_reg[0]     <= table_data;
            words_reg[0][0] <= word_in_0;
            words_reg[0][1] <= word_in_1;
            words_reg[0][2] <= word_in_2;
            words_reg[0][3] <= word_in_3;
        end
        for (int k = 1; k <= sxl_pkg::ROUNDS; k++)
        begin
            if (ready[k])
            begin
                cmd_reg[k]   <= cmd_reg[k-1];
                words_reg[k] <= words_reg[k-1];
                flag_reg[k]  <= flag_any[k-1];
            end
        end
        // The table fields are needed only up to the stage that feeds the last round.
        for (int k = 1; k < sxl_pkg::ROUNDS; k++)
        begin
            if (ready[k])
            begin
                sel_reg[k]  <= sel_reg[k-1];
                addr_reg[k] <= addr_reg[k-1];
                data_reg[k] <= data_reg[k-1];
            end
        end
        // Last XOR of neighbors, then the feed-forward XOR with the inputs.
        if (out_ready)
        begin
            for (int i = 0; i < sxl_pkg::WORDS_PER_VECTOR; i++)
            begin
                word_out_reg[i] <= rd_q[sxl_pkg::ROUNDS][i].data
                    ^ rd_q[sxl_pkg::ROUNDS][i+1].data
                    ^ words_reg[sxl_pkg::ROUNDS][i];
            end
            flag_out_reg <= flag_any[sxl_pkg::ROUNDS];
        end
    end

    assign out_valid        = out_valid_reg;
    assign word_out_0       = word_out_reg[0];
    assign word_out_1       = word_out_reg[1];
    assign word_out_2       = word_out_reg[2];
    assign word_out_3       = word_out_reg[3];
    assign unset_entry_used = flag_out_reg;

    // The input side only stalls when stage 0 is actually occupied.
    `SXL_ASSERT_SAME(a_stall_needs_item, in_stall, valid_reg[0],
        "input stalled while stage 0 is empty")

    // A write beat leaving the last stage must not produce a result.
    `SXL_ASSERT_NEXT(a_write_no_result,
        valid_reg[sxl_pkg::ROUNDS] && (cmd_reg[sxl_pkg::ROUNDS] == sxl_pkg::CMD_WRITE) && out_ready,
        !out_valid_reg, "write beat produced a result")

    // An evaluate beat leaving the last stage must produce a result.
    `SXL_ASSERT_NEXT(a_eval_result,
        valid_reg[sxl_pkg::ROUNDS] && (cmd_reg[sxl_pkg::ROUNDS] == sxl_pkg::CMD_EVALUATE) && out_ready,
        out_valid_reg, "evaluate beat lost before the output register")

endmodule

`default_nettype wire
